[hw/rtl/tbva_pkg.sv]
// tbva_pkg: shared constants, codes and types for the time-binned vector averager
// used by the channel interfaces, the serial divider and the top level
// no dependencies
package tbva_pkg;

    localparam int unsigned VALUE_WIDTH_DEF = 32;
    localparam int unsigned TIME_WIDTH_DEF  = 48;
    localparam int unsigned COUNT_WIDTH_DEF = 16;

    localparam int unsigned START_W    = 48;
    localparam int unsigned BINW_W     = 40;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] CFG_START_TIME = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = CFG_IDX_W'(1);

    localparam logic [BINW_W-1:0] BIN_WIDTH_RST = BINW_W'(60000);

    // ms from the 1958 epoch to the 2000 epoch
    localparam logic [64:0] EPOCH_2000_MS = 65'd1325376000000;

    // channel lanes
    localparam int unsigned NUM_CH = 4;
    localparam logic [1:0] CH_TOTAL = 2'd0;
    localparam logic [1:0] CH_X     = 2'd1;
    localparam logic [1:0] CH_Y     = 2'd2;
    localparam logic [1:0] CH_Z     = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_EOF,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_STORE
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

endpackage

[hw/rtl/tbva_in_if.sv]
// tbva_in_if: sample channel with valid/ready handshake
// depends on tbva_pkg
interface tbva_in_if import tbva_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic        [TIME_WIDTH-1:0]  sample_time;
    logic signed [VALUE_WIDTH-1:0] mag_x;
    logic signed [VALUE_WIDTH-1:0] mag_y;
    logic signed [VALUE_WIDTH-1:0] mag_z;
    logic signed [VALUE_WIDTH-1:0] mag_total;
    logic                          end_of_file;

    modport source (
        output valid, sample_time, mag_x, mag_y, mag_z, mag_total, end_of_file,
        input  ready
    );
    modport sink (
        input  valid, sample_time, mag_x, mag_y, mag_z, mag_total, end_of_file,
        output ready
    );
endinterface

[hw/rtl/tbva_out_if.sv]
// tbva_out_if: result channel with valid/ready handshake
// depends on tbva_pkg
interface tbva_out_if import tbva_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) ();
    logic                          valid;
    logic                          ready;
    logic signed [TIME_WIDTH:0]    out_time;
    logic signed [VALUE_WIDTH-1:0] avg_total;
    logic signed [VALUE_WIDTH-1:0] avg_x;
    logic signed [VALUE_WIDTH-1:0] avg_y;
    logic signed [VALUE_WIDTH-1:0] avg_z;
    logic        [COUNT_WIDTH-1:0] sample_count;
    logic                          bin_overflow;
    logic                          last_result;

    modport source (
        output valid, out_time, avg_total, avg_x, avg_y, avg_z, sample_count,
               bin_overflow, last_result,
        input  ready
    );
    modport sink (
        input  valid, out_time, avg_total, avg_x, avg_y, avg_z, sample_count,
               bin_overflow, last_result,
        output ready
    );
endinterface

[hw/rtl/tbva_cfg_if.sv]
// tbva_cfg_if: register write channel with valid/ready handshake
// depends on tbva_pkg
interface tbva_cfg_if import tbva_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, idx, data, input ready);
    modport sink   (input valid, idx, data, output ready);
endinterface

[hw/rtl/tbva_div.sv]
// tbva_div: serial restoring divider, signed dividend by unsigned divisor,
// one quotient bit per cycle, quotient truncated toward zero; depends on tbva_pkg
module tbva_div import tbva_pkg::*; #(
    parameter int unsigned NUM_W = 48,
    parameter int unsigned DEN_W = 16,
    parameter int unsigned QUO_W = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic signed [NUM_W-1:0] i_num,
    input  logic        [DEN_W-1:0] i_den,
    output logic signed [QUO_W-1:0] o_quo,
    output t_div_sts                o_sts
);
    localparam int unsigned STEP_W = $clog2(NUM_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic              r_neg;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [NUM_W-1:0]  r_acc;

    logic [NUM_W-1:0]  w_num_u;
    logic [NUM_W-1:0]  w_mag;
    logic [DEN_W:0]    w_trial;
    logic [DEN_W:0]    w_diff;
    logic              w_ge;
    logic [NUM_W-1:0]  w_quo;

    assign w_num_u = $unsigned(i_num);
    assign w_mag   = i_num[NUM_W-1] ? (~w_num_u + NUM_W'(1)) : w_num_u;

    // shift the next dividend bit into the partial remainder
    assign w_trial = {r_rem, r_acc[NUM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - STEP_W'(1);
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_acc <= w_mag;
            r_neg <= i_num[NUM_W-1];
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_acc <= {r_acc[NUM_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
        end
    end

    assign w_quo      = r_neg ? (~r_acc + NUM_W'(1)) : r_acc;
    assign o_quo      = $signed(w_quo[QUO_W-1:0]);
    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;

endmodule

[hw/rtl/time_binned_vector_averager.sv]
// time_binned_vector_averager: top level of the time-binned four-channel averager
// depends on tbva_pkg, tbva_in_if, tbva_out_if, tbva_cfg_if and tbva_div
//
// usage
//   i_smp carries one timestamped sample per transaction (time in ms, four signed
//   Q23.8 channels, end-of-file flag); o_res carries one bin average per
//   transaction; i_cfg writes start_time (index 0) and bin_width (index 1), taken
//   at any cycle but meant only while the block is idle
// sample handling
//   a sample that lands inside the open bin passes through accept, evaluate and
//   end-of-file check; a sample that emits a bin also runs one serial divider
//   over the four channel sums in turn, one quotient bit a cycle, before the
//   result is stored; a sample that closes a bin and also flushes runs the
//   divider over all four sums twice
//   i_smp.ready is high only in the idle state, one sample at a time
// reset
//   synchronous active-low; bin empty, start_time 0, bin_width 60000, reference
//   time 0, result register empty
// receiver stall
//   results sit in an output register; the next sample is accepted while a
//   result waits, and the sequencer only holds when a second result is ready to
//   be stored before the first has been taken
module time_binned_vector_averager import tbva_pkg::*; #(
    parameter int unsigned VALUE_WIDTH = VALUE_WIDTH_DEF,
    parameter int unsigned TIME_WIDTH  = TIME_WIDTH_DEF,
    parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tbva_in_if.sink     i_smp,
    tbva_cfg_if.sink    i_cfg,
    tbva_out_if.source  o_res
);
    // sums of up to 2^COUNT_WIDTH-1 values never leave this width
    localparam int unsigned SUM_W = VALUE_WIDTH + COUNT_WIDTH;
    localparam int unsigned CMP_W = (TIME_WIDTH > BINW_W) ? TIME_WIDTH : BINW_W;

    typedef struct packed {
        logic in_ready;
        logic acc_add;     // add the sample into the open bin
        logic set_ovf;     // bin full, drop the sample
        logic open_bin;    // start a new bin from the sample
        logic clear_bin;   // empty the bin and reload the reference
        logic close_set;   // the pending emission closes a bin
        logic close_clr;   // the pending emission is a flush
        logic div_start;
        logic q_we;
        logic out_load;
    } t_ctl;

    t_state r_state;
    t_state n_state;
    t_ctl   ctl;

    // configuration
    logic [START_W-1:0]    r_start;
    logic [BINW_W-1:0]     r_binw;

    // bin state
    logic signed [SUM_W-1:0] r_sum [NUM_CH];
    logic [COUNT_WIDTH-1:0]  r_count;
    logic [TIME_WIDTH-1:0]   r_ref;
    logic                    r_ovf;

    // captured sample
    logic [TIME_WIDTH-1:0]         r_t;
    logic signed [VALUE_WIDTH-1:0] r_v [NUM_CH];
    logic                          r_eof;
    logic [TIME_WIDTH:0]           r_out_time;
    logic                          r_closing;

    // divider sequencing
    logic [1:0]                    r_chan;
    logic signed [VALUE_WIDTH-1:0] r_q [NUM_CH];

    // result register
    logic                          r_o_valid;
    logic [TIME_WIDTH:0]           r_o_time;
    logic signed [VALUE_WIDTH-1:0] r_o_avg [NUM_CH];
    logic [COUNT_WIDTH-1:0]        r_o_count;
    logic                          r_o_ovf;
    logic                          r_o_last;

    logic [TIME_WIDTH-1:0]         w_diff;
    logic                          w_inside;
    logic                          w_full;
    logic                          w_nonempty;
    logic                          w_out_free;
    logic signed [VALUE_WIDTH-1:0] w_quo;
    t_div_sts                      w_div_sts;

    // bin membership: earlier than the reference, or less than bin_width after it
    assign w_diff     = r_t - r_ref;
    assign w_inside   = (r_t < r_ref) || (CMP_W'(w_diff) < CMP_W'(r_binw));
    assign w_full     = (r_count == '1);
    assign w_nonempty = (r_count != '0);
    assign w_out_free = !r_o_valid || o_res.ready;

    // shared divider, one channel sum at a time
    tbva_div #(
        .NUM_W (SUM_W),
        .DEN_W (COUNT_WIDTH),
        .QUO_W (VALUE_WIDTH)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (ctl.div_start),
        .i_num   (r_sum[r_chan]),
        .i_den   (r_count),
        .o_quo   (w_quo),
        .o_sts   (w_div_sts)
    );

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_smp.valid) n_state = ST_EVAL;
            end
            ST_EVAL: begin
                if (!w_inside && w_nonempty) n_state = ST_DIV_START;
                else                          n_state = ST_EOF;
            end
            ST_EOF: begin
                if (r_eof && w_nonempty) n_state = ST_DIV_START;
                else                     n_state = ST_IDLE;
            end
            ST_DIV_START: begin
                n_state = ST_DIV_WAIT;
            end
            ST_DIV_WAIT: begin
                if (w_div_sts.done) begin
                    n_state = (r_chan == CH_Z) ? ST_STORE : ST_DIV_START;
                end
            end
            ST_STORE: begin
                if (w_out_free) n_state = r_closing ? ST_EOF : ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        ctl = '0;
        unique case (r_state)
            ST_IDLE: begin
                ctl.in_ready = 1'b1;
            end
            ST_EVAL: begin
                ctl.acc_add   = w_inside && !w_full;
                ctl.set_ovf   = w_inside && w_full;
                ctl.open_bin  = !w_inside && !w_nonempty;
                ctl.close_set = !w_inside && w_nonempty;
            end
            ST_EOF: begin
                ctl.close_clr = r_eof && w_nonempty;
                ctl.clear_bin = r_eof && !w_nonempty;
            end
            ST_DIV_START: begin
                ctl.div_start = 1'b1;
            end
            ST_DIV_WAIT: begin
                ctl.q_we = w_div_sts.done;
            end
            ST_STORE: begin
                ctl.out_load  = w_out_free;
                ctl.open_bin  = w_out_free && r_closing;
                ctl.clear_bin = w_out_free && !r_closing;
            end
            default: ctl = '0;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_chan    <= '0;
            r_o_valid <= 1'b0;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_start   <= '0;
            r_binw    <= BIN_WIDTH_RST;
            r_ref     <= '0;
            r_closing <= 1'b0;
        end else begin
            r_state <= n_state;

            if (ctl.q_we) r_chan <= r_chan + 2'd1;

            if (ctl.out_load)       r_o_valid <= 1'b1;
            else if (o_res.ready)   r_o_valid <= 1'b0;

            if (ctl.close_set)      r_closing <= 1'b1;
            else if (ctl.close_clr) r_closing <= 1'b0;

            if (ctl.acc_add) r_count <= r_count + COUNT_WIDTH'(1);
            if (ctl.set_ovf) r_ovf   <= 1'b1;
            if (ctl.open_bin) begin
                r_count <= COUNT_WIDTH'(1);
                r_ovf   <= 1'b0;
                r_ref   <= r_t;
            end
            if (ctl.clear_bin) begin
                r_count <= '0;
                r_ovf   <= 1'b0;
                r_ref   <= TIME_WIDTH'(r_start);
            end

            // register writes: the user is to write only while idle; the block itself does not enforce it
            if (i_cfg.valid) begin
                unique case (i_cfg.idx)
                    CFG_START_TIME: begin
                        r_start <= i_cfg.data[START_W-1:0];
                        if (!w_nonempty) r_ref <= TIME_WIDTH'(i_cfg.data[START_W-1:0]);
                    end
                    CFG_BIN_WIDTH: begin
                        r_binw <= i_cfg.data[BINW_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (ctl.in_ready && i_smp.valid) begin
            r_t          <= i_smp.sample_time;
            r_v[CH_TOTAL] <= i_smp.mag_total;
            r_v[CH_X]    <= i_smp.mag_x;
            r_v[CH_Y]    <= i_smp.mag_y;
            r_v[CH_Z]    <= i_smp.mag_z;
            r_eof        <= i_smp.end_of_file;
            r_out_time   <= {1'b0, i_smp.sample_time} - EPOCH_2000_MS[TIME_WIDTH:0];
        end

        // the first sample after reset may add into an empty bin, so the sums start at zero
        if (!i_rst_n) begin
            for (int c = 0; c < NUM_CH; c++) r_sum[c] <= '0;
        end else begin
            for (int c = 0; c < NUM_CH; c++) begin
                if (ctl.acc_add)   r_sum[c] <= r_sum[c] + SUM_W'(r_v[c]);
                if (ctl.open_bin)  r_sum[c] <= SUM_W'(r_v[c]);
                if (ctl.clear_bin) r_sum[c] <= '0;
            end
        end

        if (ctl.q_we) r_q[r_chan] <= w_quo;

        if (ctl.out_load) begin
            r_o_time  <= r_out_time;
            r_o_avg   <= r_q;
            r_o_count <= r_count;
            r_o_ovf   <= r_ovf;
            // a closing result is followed by a flush when the sample ends the file
            r_o_last  <= !(r_closing && r_eof);
        end
    end

    // ports
    assign i_smp.ready        = ctl.in_ready;
    assign i_cfg.ready        = 1'b1;
    assign o_res.valid        = r_o_valid;
    assign o_res.out_time     = $signed(r_o_time);
    assign o_res.avg_total    = r_o_avg[CH_TOTAL];
    assign o_res.avg_x        = r_o_avg[CH_X];
    assign o_res.avg_y        = r_o_avg[CH_Y];
    assign o_res.avg_z        = r_o_avg[CH_Z];
    assign o_res.sample_count = r_o_count;
    assign o_res.bin_overflow = r_o_ovf;
    assign o_res.last_result  = r_o_last;

    // a result must never overwrite one that has not been taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.out_load |-> (!r_o_valid || o_res.ready))
        else $error("result register overwritten");

    // the divider is never restarted mid-division, and never divides by zero
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ctl.div_start |-> (!w_div_sts.busy && r_count != '0))
        else $error("bad divider start");

    // a reported overflow implies the bin was full
    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_o_valid && r_o_ovf) |-> (r_o_count == '1))
        else $error("overflow flagged on a bin that was not full");

    // an accepted sample is evaluated in the next cycle
    a_accept_eval: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_smp.valid && i_smp.ready) |=> (r_state == ST_EVAL))
        else $error("accepted sample not evaluated");

    // all four channels are divided before a result is stored
    a_chan_wrap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STORE) |-> (r_chan == CH_TOTAL))
        else $error("channel sequence out of step");

endmodule
